/* design/conv2d_zero_pad_mac_top_defines.svh */
// Assertion macros used by the conv2d_zero_pad_mac checker file.
`ifndef CONV2D_ZERO_PAD_MAC_TOP_DEFINES_SVH
`define CONV2D_ZERO_PAD_MAC_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define C2D_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("conv2d_zero_pad_mac: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define C2D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("conv2d_zero_pad_mac: assertion failed");

`endif

/* design/c2d_pkg.sv */
// Shared constants, codes and types for the 2D convolution block.
package c2d_pkg;

    // Default store bounds
    localparam int MAX_KERNEL_DIM_DEF = 16;
    localparam int MAX_IMAGE_DIM_DEF  = 64;

    // Fixed-point and centering constants
    localparam int FRAC_BITS  = 14;
    localparam int CENTER_DIV = 2;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int POS_W    = 6;
    localparam int SAMPLE_W = 16;
    localparam int RESULT_W = 32;
    localparam int KDIM_W   = 5;
    localparam int IDIM_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;

    // Actions
    localparam logic [ACTION_W-1:0] ACT_LOAD_COEF  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_PIXEL = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 3'd3;

    // Configuration reset values
    localparam logic [KDIM_W-1:0] KERNEL_ROWS_RST = 5'd3;
    localparam logic [KDIM_W-1:0] KERNEL_COLS_RST = 5'd3;
    localparam logic [IDIM_W-1:0] IMAGE_ROWS_RST  = 7'd64;
    localparam logic [IDIM_W-1:0] IMAGE_COLS_RST  = 7'd64;

    // Sequencer to MAC control
    typedef struct packed {
        logic clear;
        logic issue;
        logic live;
    } mac_ctrl_t;

endpackage

/* design/c2d_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module c2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/c2d_mac.sv */
// Shared multiply-accumulate unit with floor scaling and 32-bit saturation.
module c2d_mac #(
    parameter int ACC_W = 41
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  c2d_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [c2d_pkg::SAMPLE_W-1:0]  pixel,
    input  logic signed [c2d_pkg::SAMPLE_W-1:0]  coef,
    output logic        [c2d_pkg::RESULT_W-1:0]  result,
    output logic                                 saturated,
    output logic                                 busy
);

    localparam int PROD_W = 2 * c2d_pkg::SAMPLE_W;

    logic                     s1_issue_reg;
    logic                     s1_live_reg;
    logic                     s2_issue_reg;
    logic                     s2_live_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  shifted;
    logic                     fits;

    // Stage 1 lines up with the RAM read latency, stage 2 with the product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_issue_reg <= 1'b0;
            s1_live_reg  <= 1'b0;
            s2_issue_reg <= 1'b0;
            s2_live_reg  <= 1'b0;
        end
        else
        begin
            s1_issue_reg <= ctrl.issue;
            s1_live_reg  <= ctrl.issue & ctrl.live;
            s2_issue_reg <= s1_issue_reg;
            s2_live_reg  <= s1_live_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= pixel * coef;
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (s2_live_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Arithmetic shift gives floor division by 2^FRAC_BITS.
    assign shifted = acc_reg >>> c2d_pkg::FRAC_BITS;
    assign fits    = (&shifted[ACC_W-1:c2d_pkg::RESULT_W-1]) |
                     (~|shifted[ACC_W-1:c2d_pkg::RESULT_W-1]);

    always_comb
    begin
        saturated = ~fits;
        if (fits)
        begin
            result = shifted[c2d_pkg::RESULT_W-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            result = {1'b1, {(c2d_pkg::RESULT_W-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(c2d_pkg::RESULT_W-1){1'b1}}};
        end
    end

    assign busy = s1_issue_reg | s2_issue_reg;

endmodule

/* design/conv2d_zero_pad_mac_top.sv */
// Zero-padded 2D convolution: stores, tap sequencer and result register.
// Load beats leave the sequencer idle; s_tready stays high after them.
// A compute beat inside the image runs kr*kc taps through one shared MAC, one tap
// read per cycle (none for an empty kernel); the result registers once drained,
// later while an earlier result waits on m_tready; the next beat is taken after.
// Reset clears control and sets the dimension registers to 3, 3, 64, 64; stores kept.
module conv2d_zero_pad_mac_top #(
    parameter int MAX_KERNEL_DIM = c2d_pkg::MAX_KERNEL_DIM_DEF,
    parameter int MAX_IMAGE_DIM  = c2d_pkg::MAX_IMAGE_DIM_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [c2d_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [c2d_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // row [5:0], col [11:6], value [27:12], zero fill above
    input  logic [c2d_pkg::S_TDATA_W-1:0]     s_tdata,
    // action [1:0]
    input  logic [c2d_pkg::ACTION_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // result_value [31:0], out_row [37:32], out_col [43:38], zero fill above
    output logic [c2d_pkg::M_TDATA_W-1:0]     m_tdata,
    // saturated [0]
    output logic                              m_tuser
);

    localparam int KDEPTH = MAX_KERNEL_DIM * MAX_KERNEL_DIM;
    localparam int IDEPTH = MAX_IMAGE_DIM * MAX_IMAGE_DIM;
    localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
    localparam int PAW    = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
    localparam int KDW    = $clog2(MAX_KERNEL_DIM + 1);
    localparam int IDW    = $clog2(MAX_IMAGE_DIM + 1);
    localparam int IXW    = $clog2(MAX_IMAGE_DIM + MAX_KERNEL_DIM + 64) + 1;
    localparam int ACC_W  = 2 * c2d_pkg::SAMPLE_W + 1 + 2 * $clog2(MAX_KERNEL_DIM);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // Input beat fields
    logic [c2d_pkg::POS_W-1:0]    in_row;
    logic [c2d_pkg::POS_W-1:0]    in_col;
    logic [c2d_pkg::SAMPLE_W-1:0] in_value;
    logic                         in_beat;

    assign in_row   = s_tdata[c2d_pkg::POS_W-1:0];
    assign in_col   = s_tdata[2*c2d_pkg::POS_W-1:c2d_pkg::POS_W];
    assign in_value = s_tdata[2*c2d_pkg::POS_W+c2d_pkg::SAMPLE_W-1:2*c2d_pkg::POS_W];
    assign in_beat  = s_tvalid & s_tready;

    // Control and configuration registers
    logic [1:0]                    state_reg, state_next;
    logic [c2d_pkg::KDIM_W-1:0]    kernel_rows_reg, kernel_rows_next;
    logic [c2d_pkg::KDIM_W-1:0]    kernel_cols_reg, kernel_cols_next;
    logic [c2d_pkg::IDIM_W-1:0]    image_rows_reg, image_rows_next;
    logic [c2d_pkg::IDIM_W-1:0]    image_cols_reg, image_cols_next;
    logic                          m_tvalid_reg, m_tvalid_next;

    // Sequencer and payload registers
    logic signed [IXW-1:0]         ii_reg, ii_next;
    logic signed [IXW-1:0]         jj_reg, jj_next;
    logic signed [IXW-1:0]         jj0_reg, jj0_next;
    logic [KDW-1:0]                fm_reg, fm_next;
    logic [KDW-1:0]                fn_reg, fn_next;
    logic [c2d_pkg::POS_W-1:0]     req_row_reg, req_row_next;
    logic [c2d_pkg::POS_W-1:0]     req_col_reg, req_col_next;
    logic [c2d_pkg::RESULT_W-1:0]  m_result_reg, m_result_next;
    logic [c2d_pkg::POS_W-1:0]     m_row_reg, m_row_next;
    logic [c2d_pkg::POS_W-1:0]     m_col_reg, m_col_next;
    logic                          m_sat_reg, m_sat_next;

    // Clamped dimensions
    logic [KDW-1:0] kr, kc, cy, cx;
    logic [IDW-1:0] ir, ic;

    assign kr = (32'(kernel_rows_reg) > 32'(MAX_KERNEL_DIM)) ?
                KDW'(MAX_KERNEL_DIM) : KDW'(kernel_rows_reg);
    assign kc = (32'(kernel_cols_reg) > 32'(MAX_KERNEL_DIM)) ?
                KDW'(MAX_KERNEL_DIM) : KDW'(kernel_cols_reg);
    assign ir = (32'(image_rows_reg) > 32'(MAX_IMAGE_DIM)) ?
                IDW'(MAX_IMAGE_DIM) : IDW'(image_rows_reg);
    assign ic = (32'(image_cols_reg) > 32'(MAX_IMAGE_DIM)) ?
                IDW'(MAX_IMAGE_DIM) : IDW'(image_cols_reg);
    assign cy = KDW'(kr / c2d_pkg::CENTER_DIV);
    assign cx = KDW'(kc / c2d_pkg::CENTER_DIV);

    logic req_in_image;
    logic coef_in_store;
    logic pix_in_store;
    logic tap_in_range;

    assign req_in_image  = (32'(in_row) < 32'(ir)) && (32'(in_col) < 32'(ic));
    assign coef_in_store = (32'(in_row) < 32'(MAX_KERNEL_DIM)) &&
                           (32'(in_col) < 32'(MAX_KERNEL_DIM));
    assign pix_in_store  = (32'(in_row) < 32'(MAX_IMAGE_DIM)) &&
                           (32'(in_col) < 32'(MAX_IMAGE_DIM));
    assign tap_in_range  = (ii_reg >= 0) && (ii_reg < $signed(IXW'(ir))) &&
                           (jj_reg >= 0) && (jj_reg < $signed(IXW'(ic)));

    // Store ports
    logic                          coef_we, pix_we;
    logic [KAW-1:0]                coef_waddr, coef_raddr;
    logic [PAW-1:0]                pix_waddr, pix_raddr;
    logic [c2d_pkg::SAMPLE_W-1:0]  coef_rdata, pix_rdata;

    assign coef_waddr = KAW'(KAW'(in_row) * KAW'(MAX_KERNEL_DIM) + KAW'(in_col));
    assign pix_waddr  = PAW'(PAW'(in_row) * PAW'(MAX_IMAGE_DIM) + PAW'(in_col));
    assign coef_raddr = KAW'(KAW'(fm_reg) * KAW'(MAX_KERNEL_DIM) + KAW'(fn_reg));
    assign pix_raddr  = PAW'(PAW'(ii_reg) * PAW'(MAX_IMAGE_DIM) + PAW'(jj_reg));

    c2d_ram #(
        .WIDTH (c2d_pkg::SAMPLE_W),
        .DEPTH (KDEPTH),
        .AW    (KAW)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (in_value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    c2d_ram #(
        .WIDTH (c2d_pkg::SAMPLE_W),
        .DEPTH (IDEPTH),
        .AW    (PAW)
    ) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (in_value),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    // Shared MAC
    c2d_pkg::mac_ctrl_t            mac_ctrl;
    logic [c2d_pkg::RESULT_W-1:0]  mac_result;
    logic                          mac_sat;
    logic                          mac_busy;

    c2d_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .pixel     ($signed(pix_rdata)),
        .coef      ($signed(coef_rdata)),
        .result    (mac_result),
        .saturated (mac_sat),
        .busy      (mac_busy)
    );

    always_comb
    begin
        state_next       = state_reg;
        kernel_rows_next = kernel_rows_reg;
        kernel_cols_next = kernel_cols_reg;
        image_rows_next  = image_rows_reg;
        image_cols_next  = image_cols_reg;
        m_tvalid_next    = m_tvalid_reg;
        ii_next          = ii_reg;
        jj_next          = jj_reg;
        jj0_next         = jj0_reg;
        fm_next          = fm_reg;
        fn_next          = fn_reg;
        req_row_next     = req_row_reg;
        req_col_next     = req_col_reg;
        m_result_next    = m_result_reg;
        m_row_next       = m_row_reg;
        m_col_next       = m_col_reg;
        m_sat_next       = m_sat_reg;
        coef_we          = 1'b0;
        pix_we           = 1'b0;
        mac_ctrl         = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                c2d_pkg::CFG_KERNEL_ROWS: kernel_rows_next = cfg_data[c2d_pkg::KDIM_W-1:0];
                c2d_pkg::CFG_KERNEL_COLS: kernel_cols_next = cfg_data[c2d_pkg::KDIM_W-1:0];
                c2d_pkg::CFG_IMAGE_ROWS:  image_rows_next  = cfg_data;
                c2d_pkg::CFG_IMAGE_COLS:  image_cols_next  = cfg_data;
                default: ;
            endcase
        end

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    case (s_tuser)
                        c2d_pkg::ACT_LOAD_COEF:  coef_we = coef_in_store;
                        c2d_pkg::ACT_LOAD_PIXEL: pix_we  = pix_in_store;
                        c2d_pkg::ACT_COMPUTE:
                        begin
                            if (req_in_image)
                            begin
                                mac_ctrl.clear = 1'b1;
                                ii_next      = $signed(IXW'(in_row)) - $signed(IXW'(cy));
                                jj_next      = $signed(IXW'(in_col)) - $signed(IXW'(cx));
                                jj0_next     = $signed(IXW'(in_col)) - $signed(IXW'(cx));
                                fm_next      = KDW'(kr - 1'b1);
                                fn_next      = KDW'(kc - 1'b1);
                                req_row_next = in_row;
                                req_col_next = in_col;
                                // empty kernel: sum stays zero
                                if (kr == '0 || kc == '0)
                                begin
                                    state_next = ST_FINISH;
                                end
                                else
                                begin
                                    state_next = ST_RUN;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                // issue one tap; flipped kernel entry walks down as the pixel walks up
                mac_ctrl.issue = 1'b1;
                mac_ctrl.live  = tap_in_range;
                if (fn_reg == '0)
                begin
                    if (fm_reg == '0)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        fm_next = fm_reg - 1'b1;
                        fn_next = KDW'(kc - 1'b1);
                        ii_next = ii_reg + 1'b1;
                        jj_next = jj0_reg;
                    end
                end
                else
                begin
                    fn_next = fn_reg - 1'b1;
                    jj_next = jj_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_result_next = mac_result;
                    m_sat_next    = mac_sat;
                    m_row_next    = req_row_reg;
                    m_col_next    = req_col_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            kernel_rows_reg <= c2d_pkg::KERNEL_ROWS_RST;
            kernel_cols_reg <= c2d_pkg::KERNEL_COLS_RST;
            image_rows_reg  <= c2d_pkg::IMAGE_ROWS_RST;
            image_cols_reg  <= c2d_pkg::IMAGE_COLS_RST;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            kernel_rows_reg <= kernel_rows_next;
            kernel_cols_reg <= kernel_cols_next;
            image_rows_reg  <= image_rows_next;
            image_cols_reg  <= image_cols_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ii_reg       <= ii_next;
        jj_reg       <= jj_next;
        jj0_reg      <= jj0_next;
        fm_reg       <= fm_next;
        fn_reg       <= fn_next;
        req_row_reg  <= req_row_next;
        req_col_reg  <= req_col_next;
        m_result_reg <= m_result_next;
        m_row_reg    <= m_row_next;
        m_col_reg    <= m_col_next;
        m_sat_reg    <= m_sat_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = c2d_pkg::M_TDATA_W'({m_col_reg, m_row_reg, m_result_reg});
    assign m_tuser  = m_sat_reg;

endmodule

/* design/c2d_checker.sv */
// Port-level checker for the convolution block, bound to the top level.
`include "conv2d_zero_pad_mac_top_defines.svh"

module c2d_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [c2d_pkg::ACTION_W-1:0]    s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [c2d_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                            m_tuser
);

    // A stalled result beat holds its payload.
    `C2D_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A new result only follows a busy compute run.
    `C2D_ASSERT_IMPL(a_result_after_run, clk, rst_n, $rose(m_tvalid), !$past(s_tready))

    // Loads and unused actions leave s_tready high in the next cycle.
    `C2D_ASSERT_NEXT(a_load_one_cycle, clk, rst_n, s_tvalid && s_tready && (s_tuser != c2d_pkg::ACT_COMPUTE), s_tready)

    // A clipped result sits at one of the two rails.
    `C2D_ASSERT_IMPL(a_sat_rails, clk, rst_n, m_tvalid && m_tuser, (m_tdata[31:0] == 32'h7FFF_FFFF) || (m_tdata[31:0] == 32'h8000_0000))

endmodule

bind conv2d_zero_pad_mac_top c2d_checker u_c2d_checker (.*);
